// ===== hw/rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned POS_WIDTH_DEF   = $clog2(CAPACITY_DEF + 1);

  localparam int unsigned OP_W = 4;
  localparam int unsigned ST_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
  localparam logic [OP_W-1:0] OP_READ       = 4'd4;
  localparam logic [OP_W-1:0] OP_WRITE      = 4'd5;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd6;
  localparam logic [OP_W-1:0] OP_ERASE      = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;
  localparam logic [OP_W-1:0] OP_PEEK       = 4'd9;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bdq_req_if #(
  parameter int unsigned VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned POS_WIDTH   = bdq_pkg::POS_WIDTH_DEF
);
  import bdq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               opcode;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [POS_WIDTH-1:0]          position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdq_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bdq_rsp_if #(
  parameter int unsigned VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned POS_WIDTH   = bdq_pkg::POS_WIDTH_DEF
);
  import bdq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [ST_W-1:0]               status;
  logic signed [VALUE_WIDTH-1:0] read_value;
  logic [POS_WIDTH-1:0]          result_position;
  logic [POS_WIDTH-1:0]          count;
  logic signed [VALUE_WIDTH-1:0] front_value;
  logic signed [VALUE_WIDTH-1:0] back_value;
  logic                          is_empty;

  modport source (
    output valid, output status, output read_value, output result_position,
    output count, output front_value, output back_value, output is_empty,
    input ready
  );
  modport sink (
    input valid, input status, input read_value, input result_position,
    input count, input front_value, input back_value, input is_empty,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_insert_erase.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Port      Transaction
// request   in   in_chan   opcode, value, position
// result    out  out_chan  status, read_value, result_position, count,
//                          front_value, back_value, is_empty
//
// A request is held in the request register; the cell row then shifts and the result
// register loads. One request per cycle sustained while the result is not stalled.
// Reset (synchronous) clears the count and valid flags; cells hold until written.
// A stalled result holds; the request register then fills and in_chan.ready falls.

module bounded_deque_with_insert_erase #(
  parameter int unsigned CAPACITY    = bdq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bdq_req_if.sink    in_chan,
  bdq_rsp_if.source  out_chan
);
  import bdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic                          req_valid_r;
  logic [OP_W-1:0]               req_op_r;
  logic signed [VALUE_WIDTH-1:0] req_val_r;
  logic [CNT_W-1:0]              req_pos_r;

  logic signed [VALUE_WIDTH-1:0] cells_r   [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              cnt_nxt;

  logic                          out_valid_r;
  logic [ST_W-1:0]               out_status_r;
  logic signed [VALUE_WIDTH-1:0] out_rd_r;
  logic [CNT_W-1:0]              out_rpos_r;
  logic [CNT_W-1:0]              out_cnt_r;
  logic signed [VALUE_WIDTH-1:0] out_front_r;
  logic signed [VALUE_WIDTH-1:0] out_back_r;
  logic                          out_empty_r;

  logic                          in_fire;
  logic                          exec_fire;
  logic                          empty;
  logic                          full;
  logic                          do_open;
  logic                          do_close;
  logic                          do_write;
  logic [CNT_W-1:0]              at;
  logic [ST_W-1:0]               status_nxt;
  logic signed [VALUE_WIDTH-1:0] rd_nxt;
  logic [CNT_W-1:0]              rpos_nxt;
  logic [IDX_W-1:0]              back_idx;
  logic signed [VALUE_WIDTH-1:0] front_nxt;
  logic signed [VALUE_WIDTH-1:0] back_nxt;

  assign exec_fire     = req_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || exec_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    empty      = (cnt_r == '0);
    full       = (cnt_r == CNT_W'(CAPACITY));
    status_nxt = ST_OK;
    rd_nxt     = '0;
    rpos_nxt   = '0;
    cnt_nxt    = cnt_r;
    do_open    = 1'b0;
    do_close   = 1'b0;
    do_write   = 1'b0;
    at         = req_pos_r;
    case (req_op_r)
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_write = 1'b1;
          at       = cnt_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_open = 1'b1;
          at      = '0;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_close = 1'b1;
          at       = '0;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (req_pos_r >= cnt_r) begin
          status_nxt = ST_RANGE;
        end else begin
          rpos_nxt = req_pos_r;
          rd_nxt   = cells_r[req_pos_r[IDX_W-1:0]];
        end
      end
      OP_WRITE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (req_pos_r >= cnt_r) begin
          status_nxt = ST_RANGE;
        end else begin
          rpos_nxt = req_pos_r;
          do_write = 1'b1;
        end
      end
      OP_ERASE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (req_pos_r >= cnt_r) begin
          status_nxt = ST_RANGE;
        end else begin
          rpos_nxt = req_pos_r;
          do_close = 1'b1;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (req_pos_r > cnt_r) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          rpos_nxt = req_pos_r;
          do_open  = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cnt_nxt = '0;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_nxt = cells_r[0];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] below;
    logic signed [VALUE_WIDTH-1:0] above;

    if (g == 0) begin : g_first
      assign below = cells_r[g];
    end else begin : g_rest
      assign below = cells_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign above = cells_r[g];
    end else begin : g_inner
      assign above = cells_r[g+1];
    end

    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (do_open && (CNT_W'(g) > at)) begin
        cells_nxt[g] = below;
      end else if (do_close && (CNT_W'(g) >= at)) begin
        cells_nxt[g] = above;
      end
      if ((do_open || do_write) && (CNT_W'(g) == at)) begin
        cells_nxt[g] = req_val_r;
      end
    end
  end

  assign back_idx  = IDX_W'(cnt_nxt - CNT_W'(1));
  assign front_nxt = (cnt_nxt == '0) ? '0 : cells_nxt[0];
  assign back_nxt  = (cnt_nxt == '0) ? '0 : cells_nxt[back_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        req_valid_r <= 1'b1;
      end else if (exec_fire) begin
        req_valid_r <= 1'b0;
      end
      if (exec_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op_r  <= in_chan.opcode;
      req_val_r <= in_chan.value;
      req_pos_r <= in_chan.position;
    end
    if (exec_fire) begin
      cells_r      <= cells_nxt;
      out_status_r <= status_nxt;
      out_rd_r     <= rd_nxt;
      out_rpos_r   <= rpos_nxt;
      out_cnt_r    <= cnt_nxt;
      out_front_r  <= front_nxt;
      out_back_r   <= back_nxt;
      out_empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.read_value      = out_rd_r;
  assign out_chan.result_position = out_rpos_r;
  assign out_chan.count           = out_cnt_r;
  assign out_chan.front_value     = out_front_r;
  assign out_chan.back_value      = out_back_r;
  assign out_chan.is_empty        = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (status_nxt != ST_OK) |=> cnt_r == $past(cnt_r))
    else $error("count changed on a failed request");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (status_nxt == ST_OK) &&
    (req_op_r == OP_PUSH_BACK || req_op_r == OP_PUSH_FRONT || req_op_r == OP_INSERT)
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("count did not grow on a successful add");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_cnt_r == '0)))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int RANDOM_REQS = 1850;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic signed [31:0] value;
    logic [4:0]        pos;
  } deque_req_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic signed [31:0] read_value;
    logic [4:0]         rpos;
    logic [4:0]         count;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic               empty;
  } deque_rsp_t;

  typedef struct packed {
    deque_req_t req;
    logic [7:0] reps;
    logic       fixed;
    deque_rsp_t rsp;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_insert_erase i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  logic signed [31:0] shadow_cells [DEPTH];
  int                 shadow_count;
  deque_rsp_t         expected_results [$];
  stim_row_t          stim_table [$];
  bit                 no_gaps;
  bit                 growing;
  int                 error_count;
  int                 sent_count;
  int                 result_count;
  int                 status_seen [4];
  int                 full_seen;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic deque_req_t make_req(input logic [OP_W-1:0] op,
                                          input logic signed [31:0] value,
                                          input logic [4:0] pos);
    deque_req_t r;
    r.op    = op;
    r.value = value;
    r.pos   = pos;
    return r;
  endfunction

  function automatic deque_rsp_t make_rsp(input logic [ST_W-1:0] status,
                                          input logic signed [31:0] rd,
                                          input logic [4:0] rpos,
                                          input logic [4:0] cnt,
                                          input logic signed [31:0] front,
                                          input logic signed [31:0] back,
                                          input logic empty);
    deque_rsp_t r;
    r.status     = status;
    r.read_value = rd;
    r.rpos       = rpos;
    r.count      = cnt;
    r.front      = front;
    r.back       = back;
    r.empty      = empty;
    return r;
  endfunction

  function automatic deque_rsp_t apply_request(input deque_req_t r);
    deque_rsp_t o;
    int         i;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          if (r.op == OP_PUSH_BACK) begin
            shadow_cells[shadow_count] = r.value;
          end else begin
            for (i = shadow_count; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[0] = r.value;
          end
          shadow_count++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          if (r.op == OP_POP_FRONT) begin
            for (i = 0; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          end
          shadow_count--;
        end
      end
      OP_READ, OP_WRITE, OP_ERASE: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else if (int'(r.pos) >= shadow_count) begin
          o.status = ST_RANGE;
        end else begin
          o.rpos = r.pos;
          if (r.op == OP_READ) begin
            o.read_value = shadow_cells[r.pos];
          end else if (r.op == OP_WRITE) begin
            shadow_cells[r.pos] = r.value;
          end else begin
            for (i = int'(r.pos); i + 1 < shadow_count; i++)
              shadow_cells[i] = shadow_cells[i+1];
            shadow_count--;
          end
        end
      end
      OP_INSERT: begin
        if (int'(r.pos) > shadow_count) begin
          o.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > int'(r.pos); i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[r.pos] = r.value;
          shadow_count++;
          o.rpos = r.pos;
        end
      end
      OP_CLEAR: begin
        if (shadow_count == 0) o.status = ST_EMPTY;
        else shadow_count = 0;
      end
      OP_PEEK: begin
        if (shadow_count == 0) o.status = ST_EMPTY;
        else o.read_value = shadow_cells[0];
      end
      default: begin
      end
    endcase
    o.count = shadow_count[4:0];
    if (shadow_count == 0) begin
      o.empty = 1'b1;
    end else begin
      o.front = shadow_cells[0];
      o.back  = shadow_cells[shadow_count-1];
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    deque_rsp_t got;
    deque_rsp_t want;
    got = make_rsp(rsp_if.status, rsp_if.read_value, rsp_if.result_position,
                   rsp_if.count, rsp_if.front_value, rsp_if.back_value, rsp_if.is_empty);
    result_count++;
    status_seen[got.status]++;
    if (got.count == 5'(DEPTH)) full_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected transaction, count", 32'(got.count), 32'd0);
    end else begin
      want = expected_results[0];
      expected_results.delete(0);
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.rpos !== want.rpos)
        report_mismatch("result_position", 32'(got.rpos), 32'(want.rpos));
      if (got.count !== want.count)
        report_mismatch("count", 32'(got.count), 32'(want.count));
      if (got.front !== want.front)
        report_mismatch("front_value", got.front, want.front);
      if (got.back !== want.back)
        report_mismatch("back_value", got.back, want.back);
      if (got.empty !== want.empty)
        report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();
  end

  always @(posedge clk) begin
    rsp_if.ready <= no_gaps || ($urandom_range(99) >= 12);
  end

  task automatic send_txn(input deque_req_t r, input bit fixed, input deque_rsp_t fixed_rsp);
    deque_rsp_t predicted;
    while (!no_gaps && $urandom_range(99) < 12) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= r.op;
    req_if.value    <= r.value;
    req_if.position <= r.pos;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = apply_request(r);
    expected_results.insert(expected_results.size(), fixed ? fixed_rsp : predicted);
    sent_count++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_row(input logic [OP_W-1:0] op, input logic signed [31:0] value,
                         input logic [4:0] pos, input int reps, input bit fixed,
                         input deque_rsp_t rsp);
    stim_row_t row;
    row.req   = make_req(op, value, pos);
    row.reps  = reps[7:0];
    row.fixed = fixed;
    row.rsp   = rsp;
    stim_table.insert(stim_table.size(), row);
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(19))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic deque_req_t random_request();
    deque_req_t r;
    int         k;
    if (shadow_count == DEPTH && $urandom_range(99) < 30) growing = 1'b0;
    if (shadow_count == 0 && $urandom_range(99) < 50) growing = 1'b1;
    if ($urandom_range(99) < 2) growing = !growing;
    k = $urandom_range(99);
    if (k < 3)       r.op = OP_W'($urandom_range(10, 15));
    else if (k < 5)  r.op = OP_CLEAR;
    else if (k < 20) r.op = OP_READ;
    else if (k < 28) r.op = OP_WRITE;
    else if (k < 32) r.op = OP_PEEK;
    else if (growing ^ ($urandom_range(99) < 15)) begin
      case ($urandom_range(2))
        0: r.op = OP_PUSH_BACK;
        1: r.op = OP_PUSH_FRONT;
        default: r.op = OP_INSERT;
      endcase
    end else begin
      case ($urandom_range(2))
        0: r.op = OP_POP_BACK;
        1: r.op = OP_POP_FRONT;
        default: r.op = OP_ERASE;
      endcase
    end
    r.value = random_value();
    if ($urandom_range(99) < 85) r.pos = 5'($urandom_range(0, shadow_count));
    else r.pos = 5'($urandom_range(0, 31));
    return r;
  endfunction

  initial begin
    deque_rsp_t empty_err;
    deque_rsp_t none;
    deque_req_t r;
    stim_row_t  row;
    int         n;
    error_count  = 0;
    sent_count   = 0;
    result_count = 0;
    full_seen    = 0;
    status_seen  = '{default: 0};
    shadow_count = 0;
    growing      = 1'b1;
    no_gaps      = 1'b0;
    for (n = 0; n < DEPTH; n++) shadow_cells[n] = '0;

    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_PUSH_BACK;
    req_if.value    <= '0;
    req_if.position <= '0;

    empty_err = make_rsp(ST_EMPTY, 0, 0, 0, 0, 0, 1'b1);
    none      = '0;
    put_row(OP_POP_BACK,  0, 0, 1, 1'b1, empty_err);
    put_row(OP_POP_FRONT, 0, 0, 1, 1'b1, empty_err);
    put_row(OP_READ,      0, 0, 1, 1'b1, empty_err);
    put_row(OP_WRITE,     5, 0, 1, 1'b1, empty_err);
    put_row(OP_ERASE,     0, 0, 1, 1'b1, empty_err);
    put_row(OP_CLEAR,     0, 0, 1, 1'b1, empty_err);
    put_row(OP_PEEK,      0, 0, 1, 1'b1, empty_err);
    put_row(OP_INSERT,    7, 1, 1, 1'b1, make_rsp(ST_RANGE, 0, 0, 0, 0, 0, 1'b1));
    put_row(OP_INSERT, 32'sh8000_0000, 0, 1, 1'b1,
            make_rsp(ST_OK, 0, 0, 1, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
    put_row(OP_PUSH_BACK, 32'sh7FFF_FFFF, 0, 1, 1'b1,
            make_rsp(ST_OK, 0, 0, 2, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0));
    put_row(OP_PUSH_FRONT, -32'sd1, 0, 1, 1'b0, none);
    put_row(OP_READ,   0, 2, 1, 1'b0, none);
    put_row(OP_READ,   0, 3, 1, 1'b0, none);
    put_row(OP_WRITE,  32'sh5555_5555, 1, 1, 1'b0, none);
    put_row(OP_PEEK,   0, 0, 1, 1'b0, none);
    put_row(OP_INSERT, 32'shAAAA_AAAA, 3, 1, 1'b0, none);
    put_row(OP_ERASE,  0, 31, 1, 1'b0, none);
    put_row(4'd15,     0, 0, 1, 1'b0, none);
    put_row(4'd10,     0, 0, 1, 1'b0, none);
    put_row(OP_ERASE,  0, 3, 1, 1'b0, none);
    put_row(OP_PUSH_BACK, 32'sh0F0F_F0F0, 0, 13, 1'b0, none);
    put_row(OP_PUSH_BACK,  1, 0, 1, 1'b0, none);
    put_row(OP_PUSH_FRONT, 2, 0, 1, 1'b0, none);
    put_row(OP_INSERT,     3, 16, 1, 1'b0, none);
    put_row(OP_INSERT,     4, 17, 1, 1'b0, none);
    put_row(OP_READ,       0, 15, 1, 1'b0, none);
    put_row(OP_ERASE,      0, 0, 1, 1'b0, none);
    put_row(OP_POP_BACK,   0, 0, 1, 1'b0, none);
    put_row(OP_POP_FRONT,  0, 0, 1, 1'b0, none);
    put_row(OP_CLEAR, 0, 0, 1, 1'b1, make_rsp(ST_OK, 0, 0, 0, 0, 0, 1'b1));
    put_row(OP_PEEK,  0, 0, 1, 1'b1, empty_err);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      for (n = 0; n < row.reps; n++) send_txn(row.req, row.fixed, row.rsp);
    end
    drain_results();

    for (n = 0; n < RANDOM_REQS; n++) begin
      no_gaps = (n >= 400 && n < 700);
      if (n == 900) drain_results();
      r = random_request();
      send_txn(r, 1'b0, none);
    end
    no_gaps = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("transactions never returned", 32'(expected_results.size()), 32'd0);
    $display("Sent %0d requests, checked %0d results; full deque seen %0d times.",
             sent_count, result_count, full_seen);
    $display("Status mix ok/empty/full/range: %0d/%0d/%0d/%0d, mismatches: %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_req_if.sv
hw/rtl/bdq_rsp_if.sv
hw/rtl/bounded_deque_with_insert_erase.sv
test/tb_top.sv
